FILE: rtl/core/ple_pkg.sv
`default_nettype none

package ple_pkg;

    // operation codes
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_GET    = 3'd3;
    localparam logic [2:0] OP_LOCATE = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_POS  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic [6:0]         position;
        logic signed [31:0] item_value;
    } t_request;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [6:0]         found_position;
        logic [6:0]         current_length;
        logic               is_empty;
    } t_result;

    // per-cell command, shared by every cell of the row
    typedef struct packed {
        logic do_insert;
        logic do_delete;
        logic find_pos;
        logic find_val;
    } t_cell_ctl;

    // search token that travels down the row towards cell 0
    typedef struct packed {
        logic        hit;
        logic [31:0] data;
    } t_carry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/ple_cell.sv
`default_nettype none

module ple_cell #(
    parameter int IDX = 0,
    parameter int LW  = 7
) (
    input  wire logic               i_clk,
    input  wire ple_pkg::t_cell_ctl i_ctl,
    input  wire logic [LW-1:0]      i_pos,
    input  wire logic [LW-1:0]      i_len,
    input  wire logic [31:0]        i_key,
    input  wire logic [31:0]        i_lo_data,
    input  wire logic [31:0]        i_hi_data,
    input  wire ple_pkg::t_carry    i_hi_carry,
    output logic [31:0]             o_data,
    output ple_pkg::t_carry         o_carry
);

    localparam logic [LW-1:0] K = LW'(IDX);

    logic [31:0]     r_data;
    logic [31:0]     n_data;
    ple_pkg::t_carry r_carry;
    ple_pkg::t_carry n_carry;
    logic            hit;

    always_comb begin
        n_data = r_data;
        if (i_ctl.do_insert) begin
            if (K == i_pos) begin
                n_data = i_key;
            end else if (K > i_pos) begin
                n_data = i_lo_data;
            end
        end else if (i_ctl.do_delete) begin
            if (K >= i_pos) begin
                n_data = i_hi_data;
            end
        end
    end

    // lower cells override, so cell 0 ends up with the first hit
    always_comb begin
        hit = 1'b0;
        if (i_ctl.find_pos) begin
            hit = (K == i_pos);
        end else if (i_ctl.find_val) begin
            hit = (K < i_len) && (r_data == i_key);
        end
        n_carry = i_hi_carry;
        if (hit) begin
            n_carry.hit  = 1'b1;
            n_carry.data = i_ctl.find_val ? 32'(IDX + 1) : r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_carry <= n_carry;
    end

    assign o_data  = r_data;
    assign o_carry = r_carry;

endmodule

`default_nettype wire

FILE: rtl/core/positional_list_engine_core.sv
`default_nettype none

// positional list engine: bounded ordered list of signed 32-bit values,
// positions counted from 1
// a request is taken on a rising edge with start high and busy low; it
// carries an operation (clear, insert, delete, get, locate), a position
// and a value
// every request gives exactly one result, shown on o_result for a single
// cycle with o_done high; the receiver cannot hold it off, so the result
// is never stalled
// clear, insert, unused codes and a get or delete with a bad position give
// the result on the cycle after acceptance, busy stays low and the next
// request can be taken straight away (one request per cycle)
// get and delete with a valid position, and every locate, hold busy high
// through the scan and finish states and show the result after them; no
// new request is taken until busy drops: the search token walks the whole
// row of cells, one cell per cycle, so the row length sets the search time
// each cell holds one entry; insert and delete move every entry at or beyond
// the position by one cell at once, so the list is never copied entry by entry
// reset (synchronous, active low) empties the list and drops any request
// in flight; entry contents are not cleared, only ever read below length
module positional_list_engine_core #(
    parameter int CAPACITY = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire ple_pkg::t_request i_request,
    output logic                   o_done,
    output ple_pkg::t_result       o_result
);

    // length counter width and compare width for the 7-bit position
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > 7) ? LW : 7;

    ple_pkg::t_state  r_state;
    ple_pkg::t_state  n_state;
    logic [LW-1:0]    r_len;
    logic [LW-1:0]    n_len;
    logic [LW-1:0]    r_cnt;
    logic [LW-1:0]    n_cnt;
    logic [2:0]       r_op;
    logic [2:0]       n_op;
    logic [LW-1:0]    r_pos;
    logic [LW-1:0]    n_pos;
    logic [31:0]      r_key;
    logic [31:0]      n_key;
    logic             r_done;
    logic             n_done;
    ple_pkg::t_result r_res;
    ple_pkg::t_result n_res;

    // request decode
    logic             accept;
    logic [CW:0]      pos_x;
    logic [CW:0]      len_x;
    logic             ins_ok;
    logic             rd_ok;
    logic             full;
    logic [LW-1:0]    pos_m1;

    // row of cells
    ple_pkg::t_cell_ctl cell_ctl;
    logic [LW-1:0]      cell_pos;
    logic [31:0]        cell_key;
    logic [31:0]        w_data  [CAPACITY];
    ple_pkg::t_carry    w_carry [CAPACITY];

    assign busy   = (r_state != ple_pkg::S_IDLE);
    assign accept = start && !busy;

    assign pos_x  = (CW + 1)'(i_request.position);
    assign len_x  = (CW + 1)'(r_len);
    assign ins_ok = (pos_x != '0) && (pos_x <= len_x + (CW + 1)'(1));
    assign rd_ok  = (pos_x != '0) && (pos_x <= len_x);
    assign full   = (r_len == LW'(CAPACITY));
    assign pos_m1 = LW'(pos_x - (CW + 1)'(1));

    // cells see the live request while idle, the held one during a search
    assign cell_pos = busy ? r_pos : pos_m1;
    assign cell_key = busy ? r_key : i_request.item_value;

    always_comb begin
        cell_ctl.do_insert = accept && (i_request.operation == ple_pkg::OP_INSERT)
                             && ins_ok && !full;
        cell_ctl.do_delete = (r_state == ple_pkg::S_FINISH)
                             && (r_op == ple_pkg::OP_DELETE);
        cell_ctl.find_pos  = (r_state == ple_pkg::S_SCAN)
                             && ((r_op == ple_pkg::OP_GET) || (r_op == ple_pkg::OP_DELETE));
        cell_ctl.find_val  = (r_state == ple_pkg::S_SCAN)
                             && (r_op == ple_pkg::OP_LOCATE);
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [31:0]     lo_data;
        logic [31:0]     hi_data;
        ple_pkg::t_carry hi_carry;

        // the ends of the row see nothing beyond them
        if (k == 0) begin : g_lo_end
            assign lo_data = '0;
        end else begin : g_lo_mid
            assign lo_data = w_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_hi_end
            assign hi_data  = '0;
            assign hi_carry = '0;
        end else begin : g_hi_mid
            assign hi_data  = w_data[k+1];
            assign hi_carry = w_carry[k+1];
        end

        ple_cell #(
            .IDX (k),
            .LW  (LW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_pos      (cell_pos),
            .i_len      (r_len),
            .i_key      (cell_key),
            .i_lo_data  (lo_data),
            .i_hi_data  (hi_data),
            .i_hi_carry (hi_carry),
            .o_data     (w_data[k]),
            .o_carry    (w_carry[k])
        );
    end

    // control: next state and result
    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_op    = r_op;
        n_pos   = r_pos;
        n_key   = r_key;
        n_done  = 1'b0;
        n_res   = r_res;

        case (r_state)
            ple_pkg::S_IDLE: begin
                if (accept) begin
                    n_res.status         = ple_pkg::STAT_OK;
                    n_res.read_value     = '0;
                    n_res.found_position = '0;
                    n_done               = 1'b1;
                    case (i_request.operation)
                        ple_pkg::OP_CLEAR: begin
                            n_len = '0;
                        end
                        ple_pkg::OP_INSERT: begin
                            if (!ins_ok) begin
                                n_res.status = ple_pkg::STAT_POS;
                            end else if (full) begin
                                n_res.status = ple_pkg::STAT_FULL;
                            end else begin
                                n_len = r_len + LW'(1);
                            end
                        end
                        ple_pkg::OP_DELETE, ple_pkg::OP_GET: begin
                            if (!rd_ok) begin
                                n_res.status = ple_pkg::STAT_POS;
                            end else begin
                                n_done  = 1'b0;
                                n_state = ple_pkg::S_SCAN;
                            end
                        end
                        ple_pkg::OP_LOCATE: begin
                            n_done  = 1'b0;
                            n_state = ple_pkg::S_SCAN;
                        end
                        default: begin
                            n_len = r_len;
                        end
                    endcase
                    n_op  = i_request.operation;
                    n_pos = pos_m1;
                    n_key = i_request.item_value;
                    n_cnt = '0;
                end
            end
            ple_pkg::S_SCAN: begin
                // scan runs until the counter has stepped through every cell, so the token can reach cell 0
                n_cnt = r_cnt + LW'(1);
                if (r_cnt == LW'(CAPACITY - 1)) begin
                    n_state = ple_pkg::S_FINISH;
                end
            end
            ple_pkg::S_FINISH: begin
                n_res.status         = ple_pkg::STAT_OK;
                n_res.read_value     = '0;
                n_res.found_position = '0;
                if (r_op == ple_pkg::OP_LOCATE) begin
                    if (w_carry[0].hit) begin
                        n_res.found_position = w_carry[0].data[6:0];
                    end
                end else begin
                    n_res.read_value = w_carry[0].data;
                    if (r_op == ple_pkg::OP_DELETE) begin
                        n_len = r_len - LW'(1);
                    end
                end
                n_done  = 1'b1;
                n_state = ple_pkg::S_IDLE;
            end
            default: begin
                n_state = ple_pkg::S_IDLE;
            end
        endcase

        n_res.current_length = 7'(n_len);
        n_res.is_empty       = (n_len == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ple_pkg::S_IDLE;
            r_len   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_done  <= n_done;
        end
    end

    // request payload and result, no reset needed
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_op  <= n_op;
        r_pos <= n_pos;
        r_key <= n_key;
        r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    // length never exceeds the row
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(CAPACITY))
        else $error("list length beyond capacity");

    // a finished search always reports on the next cycle
    a_finish_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ple_pkg::S_FINISH) |=> o_done)
        else $error("search finished without a result");

    // an accepted locate request starts a search, raising busy without a result
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_request.operation == ple_pkg::OP_LOCATE)) |=> (busy && !o_done))
        else $error("locate request did not start a search");

    // length only moves by one step, or to zero on clear
    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_len != $past(r_len)) |->
            (r_len == '0) || (r_len == $past(r_len) + LW'(1))
            || (r_len == $past(r_len) - LW'(1)))
        else $error("list length jumped");

endmodule

`default_nettype wire
